@@ hdl/sse_pkg.sv @@
package sse_pkg;

  // element width of the sorted set
  localparam int unsigned ValueW = 32;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_GAP,
    ST_HOLD,
    ST_CMP,
    ST_PUT,
    ST_OUT
  } state_e;

endpackage

@@ hdl/sse_ram.sv @@
module sse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/shell_sort_engine.sv @@
// Shell sort engine. Values are loaded one beat per cycle (start_i while busy_o is low) into a
// local store of DEPTH entries; a value arriving with the store full is dropped, but its last_i
// mark still ends the set. After the beat marked last_i the block raises busy_o and sorts the n
// stored values in ascending signed order with gaps n/2, n/4, ... 1, each pass a gapped insertion
// sort run against a single store with one write and one registered read per cycle. Each gap
// pass fetches each element in turn, compares it with its gapped neighbours and shifts them up by
// a gap while they are larger (a trailing write-back when the shift chain runs to the front); the
// sort closes once the gap reaches zero. The results then stream out one per cycle, n in all,
// strobe_o marking each beat and last_out_o the final one; they must be taken as they appear, as
// the receiver has no way to stall the block. busy_o drops in the cycle after the final result
// beat and a new set may begin at once.
module shell_sort_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [sse_pkg::ValueW-1:0] value_i,
  input  logic                             last_i,
  output logic                             strobe_o,
  output logic signed [sse_pkg::ValueW-1:0] sorted_value_o,
  output logic                             last_out_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  sse_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] gap_q, gap_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] k_q, k_d;
  logic [sse_pkg::ValueW-1:0] held_q, held_d;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [sse_pkg::ValueW-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [sse_pkg::ValueW-1:0] ram_rdata;

  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] n_next;
  logic [CW-1:0] i_nx;
  logic [CW-1:0] i_less;
  logic [CW-1:0] k_less;
  logic [CW-1:0] k_back;
  logic          store_free;

  assign cnt_inc    = count_q + CW'(1);
  assign store_free = (count_q < DepthC);
  assign n_next     = store_free ? cnt_inc : count_q;
  assign i_nx       = i_q + CW'(1);
  assign i_less     = i_q - gap_q;
  assign k_less     = k_q - gap_q;
  assign k_back     = k_less - gap_q;

  // element store
  sse_ram #(
    .WIDTH(sse_pkg::ValueW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sse_pkg::ST_LOAD;
      count_q <= '0;
      n_q     <= '0;
      gap_q   <= '0;
      i_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      n_q     <= n_d;
      gap_q   <= gap_d;
      i_q     <= i_d;
      k_q     <= k_d;
    end
  end

  // element held out during an insertion
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  // sequencer: load, gapped insertion passes, output stream
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    n_d        = n_q;
    gap_d      = gap_q;
    i_d        = i_q;
    k_d        = k_q;
    held_d     = held_q;
    ram_we     = 1'b0;
    ram_waddr  = count_q[AW-1:0];
    ram_wdata  = value_i;
    ram_raddr  = i_q[AW-1:0];
    strobe_o   = 1'b0;
    last_out_o = 1'b0;

    unique case (state_q)
      sse_pkg::ST_LOAD: begin
        if (start_i) begin
          if (store_free) begin
            ram_we  = 1'b1;
            count_d = cnt_inc;
          end
          if (last_i) begin
            n_d     = n_next;
            gap_d   = n_next >> 1;
            state_d = sse_pkg::ST_GAP;
          end
        end
      end

      sse_pkg::ST_GAP: begin
        if (gap_q == '0) begin
          // sorted: fetch first element for output
          i_d       = '0;
          ram_raddr = '0;
          state_d   = sse_pkg::ST_OUT;
        end else begin
          i_d       = gap_q;
          ram_raddr = gap_q[AW-1:0];
          state_d   = sse_pkg::ST_HOLD;
        end
      end

      sse_pkg::ST_HOLD: begin
        // take element i out, fetch its gapped neighbor
        held_d    = ram_rdata;
        k_d       = i_q;
        ram_raddr = i_less[AW-1:0];
        state_d   = sse_pkg::ST_CMP;
      end

      sse_pkg::ST_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = k_q[AW-1:0];
        if ($signed(ram_rdata) > $signed(held_q)) begin
          // shift neighbor up by one gap
          ram_wdata = ram_rdata;
          k_d       = k_less;
          if (k_less >= gap_q) begin
            ram_raddr = k_back[AW-1:0];
          end else begin
            state_d = sse_pkg::ST_PUT;
          end
        end else begin
          ram_wdata = held_q;
          if (i_nx < n_q) begin
            i_d       = i_nx;
            ram_raddr = i_nx[AW-1:0];
            state_d   = sse_pkg::ST_HOLD;
          end else begin
            gap_d   = gap_q >> 1;
            state_d = sse_pkg::ST_GAP;
          end
        end
      end

      sse_pkg::ST_PUT: begin
        // drop held element at the front of its chain
        ram_we    = 1'b1;
        ram_waddr = k_q[AW-1:0];
        ram_wdata = held_q;
        if (i_nx < n_q) begin
          i_d       = i_nx;
          ram_raddr = i_nx[AW-1:0];
          state_d   = sse_pkg::ST_HOLD;
        end else begin
          gap_d   = gap_q >> 1;
          state_d = sse_pkg::ST_GAP;
        end
      end

      sse_pkg::ST_OUT: begin
        // one result beat per cycle, next read in flight
        strobe_o   = 1'b1;
        last_out_o = (i_nx == n_q);
        ram_raddr  = i_nx[AW-1:0];
        i_d        = i_nx;
        if (i_nx == n_q) begin
          count_d = '0;
          state_d = sse_pkg::ST_LOAD;
        end
      end

      default: begin
        state_d = sse_pkg::ST_LOAD;
      end
    endcase
  end

  assign busy_o         = (state_q != sse_pkg::ST_LOAD);
  assign sorted_value_o = ram_rdata;

endmodule
